### rtl/diff_drive_duty_mixer_macros.svh
// Assertion helpers shared by ddm_duty_lane and diff_drive_duty_mixer.
// Each one samples on clk and is held off while rst is high.
`ifndef DIFF_DRIVE_DUTY_MIXER_MACROS_SVH
`define DIFF_DRIVE_DUTY_MIXER_MACROS_SVH

// Same-cycle implication.
`define DDM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ddm_pkg.sv
package ddm_pkg;

  localparam int DDM_ACC_WIDTH = 32;
  localparam int DDM_CMD_WIDTH = 16;

  localparam int CNT_W   = 16;  // encoder count field
  localparam int LIM_W   = 15;  // limit / band registers
  localparam int HB_W    = 16;  // half base, Q0.16
  localparam int HB_FRAC = 16;
  localparam int GAIN_W  = 16;  // gain, Q8.8
  localparam int GAIN_FRAC = 8;
  localparam int VEL_W   = 16;  // clamped command, signed
  localparam int SPIN_W  = VEL_W + HB_W + 1;
  localparam int TERM_W  = SPIN_W + 1;
  localparam int MAG_W   = TERM_W - 1;
  localparam int NUM_W   = 40;  // magnitude * 100
  localparam int DUTY_W  = 7;
  localparam int OUT_W   = 16;
  localparam int SUM_W   = 10;  // duty +/- correction, signed

  localparam int DIV_STEPS = 8;
  localparam int STEP_W    = 3;

  localparam int ERR_W    = 15;             // error bits that reach the multiplier
  localparam int PROD_W   = ERR_W + GAIN_W;
  localparam int CAP_BITS = 7;              // correction capped at 2^7
  localparam int DELTA_W  = CAP_BITS + 1;

  localparam logic [DUTY_W-1:0]  DUTY_MAX  = 7'd100;
  localparam logic [DELTA_W-1:0] DELTA_CAP = 8'd128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_BAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ENABLE = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SPIN,
    ST_TERM,
    ST_START,
    ST_WAIT,
    ST_MERGE
  } ddm_state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV,
    LN_DONE
  } lane_state_t;

  typedef struct packed {
    logic err_load;   // latch accumulator difference
    logic mul_load;   // latch error * gain
    logic apply;      // correction active for this tick
  } merge_ctrl_t;

endpackage

### rtl/ddm_duty_lane.sv
// One wheel: |term| * 100 / (limit << 16), restoring division one bit a cycle.
module ddm_duty_lane import ddm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [TERM_W-1:0] term,
  input  logic [LIM_W-1:0]         limit,
  output logic                     done,
  output logic [DUTY_W-1:0]        duty
);

  lane_state_t        state, state_next;
  logic [MAG_W-1:0]   mag;
  logic [LIM_W-1:0]   den;
  logic [NUM_W-1:0]   rem;
  logic [NUM_W-1:0]   scaled;
  logic [NUM_W-1:0]   dsh;
  logic               ge;
  logic [DUTY_W-1:0]  quot;
  logic               sat;
  logic [STEP_W-1:0]  step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      LN_IDLE: if (start) state_next = LN_MUL;
      LN_MUL:  state_next = LN_DIV;
      LN_DIV:  if (step == '0) state_next = LN_DONE;
      LN_DONE: if (start) state_next = LN_MUL;
      default: state_next = LN_IDLE;
    endcase
  end

  always_comb begin
    scaled = mag * DUTY_MAX;
    dsh    = NUM_W'({den, {HB_FRAC{1'b0}}}) << step;
    ge     = rem >= dsh;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= term[TERM_W-1] ? MAG_W'(-term) : MAG_W'(term);
      den <= limit;
    end
    case (state)
      LN_MUL: begin
        rem  <= scaled;
        quot <= '0;
        sat  <= 1'b0;
        step <= STEP_W'(DIV_STEPS - 1);
      end
      LN_DIV: begin
        // top step only detects a quotient of 128 or more
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          sat <= ge;
        end else begin
          if (ge) rem <= rem - dsh;
          quot <= {quot[DUTY_W-2:0], ge};
        end
        step <= step - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (den == '0) begin
      duty = (mag != '0) ? DUTY_MAX : '0;
    end else if (sat || quot > DUTY_MAX) begin
      duty = DUTY_MAX;
    end else begin
      duty = quot;
    end
  end

  assign done = (state == LN_DONE);

  `include "diff_drive_duty_mixer_macros.svh"

  `DDM_ASSERT_IMPL(a_lane_duty_cap, state == LN_DONE, duty <= DUTY_MAX, "lane duty over 100")

endmodule

### rtl/ddm_balance_merge.sv
// Encoder balance: gain * (left_sum - right_sum) / 256 moved between the duties.
module ddm_balance_merge import ddm_pkg::*; #(
  parameter int ACC_WIDTH = DDM_ACC_WIDTH
) (
  input  logic                        clk,
  input  merge_ctrl_t                 ctrl,
  input  logic signed [ACC_WIDTH-1:0] left_sum,
  input  logic signed [ACC_WIDTH-1:0] right_sum,
  input  logic [GAIN_W-1:0]           gain,
  input  logic [DUTY_W-1:0]           left_raw,
  input  logic [DUTY_W-1:0]           right_raw,
  output logic [DUTY_W-1:0]           left_duty,
  output logic [DUTY_W-1:0]           right_duty
);

  logic signed [ACC_WIDTH:0] diff;
  logic [ACC_WIDTH:0]        absd;
  logic                      err_neg;
  logic                      err_big;
  logic [ERR_W-1:0]          err_low;
  logic [PROD_W-1:0]         prod;
  logic                      gain_nz;
  logic [DELTA_W-1:0]        dmag;
  logic signed [SUM_W-1:0]   delta;
  logic signed [SUM_W-1:0]   lsum;
  logic signed [SUM_W-1:0]   rsum;

  always_comb begin
    diff = (ACC_WIDTH + 1)'(left_sum) - (ACC_WIDTH + 1)'(right_sum);
    absd = diff[ACC_WIDTH] ? (ACC_WIDTH + 1)'(-diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (ctrl.err_load) begin
      err_neg <= diff[ACC_WIDTH];
      err_big <= |absd[ACC_WIDTH:ERR_W];
      err_low <= absd[ERR_W-1:0];
    end
    if (ctrl.mul_load) begin
      prod    <= err_low * gain;
      gain_nz <= (gain != '0);
    end
  end

  // duties are 0..100, so any correction of 128 or more saturates both sides
  always_comb begin
    if (!ctrl.apply) begin
      dmag = '0;
    end else if ((err_big && gain_nz) || (|prod[PROD_W-1:GAIN_FRAC+CAP_BITS])) begin
      dmag = DELTA_CAP;
    end else begin
      dmag = {1'b0, prod[GAIN_FRAC+CAP_BITS-1:GAIN_FRAC]};
    end
    delta = err_neg ? -SUM_W'(dmag) : SUM_W'(dmag);
    lsum  = SUM_W'(left_raw) - delta;
    rsum  = SUM_W'(right_raw) + delta;

    if (lsum < 0) left_duty = '0;
    else if (lsum > SUM_W'(DUTY_MAX)) left_duty = DUTY_MAX;
    else left_duty = lsum[DUTY_W-1:0];

    if (rsum < 0) right_duty = '0;
    else if (rsum > SUM_W'(DUTY_MAX)) right_duty = DUTY_MAX;
    else right_duty = rsum[DUTY_W-1:0];
  end

endmodule

### rtl/diff_drive_duty_mixer.sv
// Channel   Signals                                       Beat
// s_        s_tvalid s_tready s_tdata                     one control tick in
// m_        m_tvalid m_tready m_tdata                     one duty pair out
// cfg_      cfg_valid cfg_ready cfg_index cfg_data        one register write
//
// A tick goes from input beat to output valid through four mixer steps
// (clamp, spin multiply, wheel terms, lane start), a x100 multiply and an
// 8-step restoring divide in each wheel lane, a done check, then the merge.
// One tick in flight; the next beat is taken while a result waits on m_tready.
// rst is synchronous: config registers return to their defaults, sums clear.
// cfg_ready is always high; write registers only while the block is idle.
module diff_drive_duty_mixer import ddm_pkg::*; #(
  parameter int ACC_WIDTH = DDM_ACC_WIDTH,
  parameter int CMD_WIDTH = DDM_CMD_WIDTH,
  localparam int IN_W = ((2 * CMD_WIDTH + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // linear_cmd, angular_cmd, left_counts, right_counts, zero pad
  input  logic [IN_W-1:0]       s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // left_duty[6:0], right_duty[13:7], left_reverse[14], right_reverse[15]
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = ((CMD_WIDTH > VEL_W) ? CMD_WIDTH : VEL_W) + 1;

  // config registers
  logic [LIM_W-1:0]  linear_limit;
  logic [LIM_W-1:0]  angular_limit;
  logic [HB_W-1:0]   half_base;
  logic [GAIN_W-1:0] balance_gain;
  logic [LIM_W-1:0]  straight_band;
  logic              balance_enable;

  ddm_state_t state, state_next;

  logic signed [CMD_WIDTH-1:0] lin_cmd;
  logic signed [CMD_WIDTH-1:0] ang_cmd;
  logic signed [CNT_W-1:0]     lc_in;
  logic signed [CNT_W-1:0]     rc_in;
  logic signed [ACC_WIDTH-1:0] left_sum;
  logic signed [ACC_WIDTH-1:0] right_sum;

  logic signed [CW-1:0]     lin_x, lin_lim, lin_c;
  logic signed [CW-1:0]     ang_x, ang_lim, ang_c;
  logic signed [VEL_W-1:0]  ang_cv;
  logic [VEL_W-1:0]         ang_abs;
  logic signed [VEL_W-1:0]  vel;
  logic signed [VEL_W-1:0]  ang;
  logic                     apply;
  logic signed [SPIN_W-1:0] spin;
  logic signed [TERM_W-1:0] term_l;
  logic signed [TERM_W-1:0] term_r;

  logic              accept;
  logic              lane_start;
  logic              lane_done_l, lane_done_r;
  logic [DUTY_W-1:0] raw_l, raw_r;
  logic [DUTY_W-1:0] duty_l, duty_r;
  logic              out_load;
  merge_ctrl_t       mctrl;

  logic [DUTY_W-1:0] out_left_duty, out_right_duty;
  logic              out_left_rev, out_right_rev;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign lc_in     = s_tdata[2*CMD_WIDTH+CNT_W-1:2*CMD_WIDTH];
  assign rc_in     = s_tdata[2*CMD_WIDTH+2*CNT_W-1:2*CMD_WIDTH+CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_limit   <= 15'd8192;
      angular_limit  <= 15'd16384;
      half_base      <= 16'd6554;
      balance_gain   <= 16'd51;
      straight_band  <= 15'd16;
      balance_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINEAR_LIMIT:   linear_limit   <= cfg_data[LIM_W-1:0];
        REG_ANGULAR_LIMIT:  angular_limit  <= cfg_data[LIM_W-1:0];
        REG_HALF_BASE:      half_base      <= cfg_data[HB_W-1:0];
        REG_BALANCE_GAIN:   balance_gain   <= cfg_data[GAIN_W-1:0];
        REG_STRAIGHT_BAND:  straight_band  <= cfg_data[LIM_W-1:0];
        REG_BALANCE_ENABLE: balance_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    lane_start     = 1'b0;
    out_load       = 1'b0;
    mctrl.err_load = 1'b0;
    mctrl.mul_load = 1'b0;
    mctrl.apply    = apply;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_CLAMP;
      end
      ST_CLAMP: state_next = ST_SPIN;
      ST_SPIN: begin
        mctrl.err_load = 1'b1;
        state_next     = ST_TERM;
      end
      ST_TERM: begin
        mctrl.mul_load = 1'b1;
        state_next     = ST_START;
      end
      ST_START: begin
        lane_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: if (lane_done_l && lane_done_r) state_next = ST_MERGE;
      ST_MERGE: begin
        // hold here while the previous result is still unclaimed
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---- encoder accumulators ----
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum  <= '0;
      right_sum <= '0;
    end else if (accept) begin
      left_sum  <= left_sum + ACC_WIDTH'(lc_in);
      right_sum <= right_sum + ACC_WIDTH'(rc_in);
    end else if (state == ST_SPIN && apply) begin
      // error already latched by the merge stage on this edge
      left_sum  <= '0;
      right_sum <= '0;
    end
  end

  // ---- command saturation and mixing ----
  always_comb begin
    lin_x   = CW'(lin_cmd);
    lin_lim = CW'(linear_limit);
    ang_x   = CW'(ang_cmd);
    ang_lim = CW'(angular_limit);
    if (lin_x > lin_lim) lin_c = lin_lim;
    else if (lin_x < -lin_lim) lin_c = -lin_lim;
    else lin_c = lin_x;
    if (ang_x > ang_lim) ang_c = ang_lim;
    else if (ang_x < -ang_lim) ang_c = -ang_lim;
    else ang_c = ang_x;
    ang_cv  = ang_c[VEL_W-1:0];
    ang_abs = ang_cv[VEL_W-1] ? VEL_W'(-ang_cv) : ang_cv;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lin_cmd <= s_tdata[CMD_WIDTH-1:0];
      ang_cmd <= s_tdata[2*CMD_WIDTH-1:CMD_WIDTH];
    end
    case (state)
      ST_CLAMP: begin
        vel   <= lin_c[VEL_W-1:0];
        ang   <= ang_cv;
        apply <= balance_enable && (ang_abs < VEL_W'(straight_band));
      end
      ST_SPIN: spin <= ang * $signed({1'b0, half_base});
      ST_TERM: begin
        term_l <= (TERM_W'(vel) <<< HB_FRAC) - TERM_W'(spin);
        term_r <= (TERM_W'(vel) <<< HB_FRAC) + TERM_W'(spin);
      end
      default: ;
    endcase
  end

  // ---- wheel lanes ----
  ddm_duty_lane u_lane_l (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .term  (term_l),
    .limit (linear_limit),
    .done  (lane_done_l),
    .duty  (raw_l)
  );

  ddm_duty_lane u_lane_r (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .term  (term_r),
    .limit (linear_limit),
    .done  (lane_done_r),
    .duty  (raw_r)
  );

  // ---- balance merge ----
  ddm_balance_merge #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_merge (
    .clk        (clk),
    .ctrl       (mctrl),
    .left_sum   (left_sum),
    .right_sum  (right_sum),
    .gain       (balance_gain),
    .left_raw   (raw_l),
    .right_raw  (raw_r),
    .left_duty  (duty_l),
    .right_duty (duty_r)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_duty  <= duty_l;
      out_right_duty <= duty_r;
      out_left_rev   <= term_l[TERM_W-1];   // direction ignores the correction
      out_right_rev  <= term_r[TERM_W-1];
    end
  end

  assign m_tdata = {out_right_rev, out_left_rev, out_right_duty, out_left_duty};

  `include "diff_drive_duty_mixer_macros.svh"

  `DDM_ASSERT_NEXT(a_sums_cleared, state == ST_SPIN && apply, left_sum == '0 && right_sum == '0, "sums not cleared after correction")
  `DDM_ASSERT_IMPL(a_lanes_in_step, 1'b1, lane_done_l == lane_done_r, "wheel lanes out of step")
  `DDM_ASSERT_IMPL(a_load_after_lanes, out_load, lane_done_l && lane_done_r, "result loaded before lanes finished")
  `DDM_ASSERT_IMPL(a_out_duty_range, m_tvalid, out_left_duty <= DUTY_MAX && out_right_duty <= DUTY_MAX, "output duty over 100")

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import ddm_pkg::*;

  // s_tdata carries four 16-bit fields, nothing to pad
  localparam int TICK_W = 2 * DDM_CMD_WIDTH + 2 * CNT_W;

  // Idle time after the pipe drains; leave some margin.
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 40;
  // No beat of any kind for this long means the block is hung.
  localparam int HANG_LIMIT    = 2000;

  localparam int N_PHASES       = 9;
  localparam int RAND_PER_PHASE = 210;
  localparam int N_DIRECTED     = 20;

  // Index with no register behind it: the write must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic signed [15:0] left_counts;
    logic signed [15:0] right_counts;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_reverse;
    logic              right_reverse;
  } duty_t;

  typedef struct packed {
    tick_t tick;
    logic  typed;  // want is written out by hand
    duty_t want;
  } dir_row_t;

  // Directed ticks, run on the reset register values:
  // linear 8192 (0.5), angular 16384 (1.0), half base 6554, gain 51,
  // band 16, balance on.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{0, 0, 0, 0},                  1'b1, '{0, 0, 0, 0}},        // all zero
    '{'{32767, 0, 0, 0},              1'b1, '{100, 100, 0, 0}},    // v saturates high
    '{'{-32768, 0, 0, 0},             1'b1, '{100, 100, 1, 1}},    // v saturates low
    '{'{8192, 0, 100, 0},             1'b0, '0},                   // small correction
    '{'{0, 32767, 0, 0},              1'b0, '0},                   // pure spin, w saturates
    '{'{0, -32768, 0, 0},             1'b0, '0},
    '{'{0, 15, 300, -300},            1'b0, '0},                   // just inside band
    '{'{0, 16, 500, 0},               1'b0, '0},                   // at band: sums kept
    '{'{0, -16, 0, 500},              1'b0, '0},                   // sums kept again
    '{'{4096, -15, 1000, 0},          1'b0, '0},                   // applies carried sums
    '{'{4096, 0, 32767, -32768},      1'b1, '{0, 100, 0, 0}},      // correction capped
    '{'{4096, 0, -32768, 32767},      1'b1, '{100, 0, 0, 0}},      // capped, other way
    '{'{32767, 32767, 0, 0},          1'b0, '0},
    '{'{-32768, -32768, -32768, -32768}, 1'b0, '0},
    '{'{32767, -32768, 32767, 32767}, 1'b0, '0},
    '{'{1, 0, 1, 0},                  1'b0, '0},                   // correction rounds to 0
    '{'{-1, 1, -1, 1},                1'b0, '0},
    '{'{8191, -1, 0, 0},              1'b0, '0},
    '{'{-8192, 0, 0, 0},              1'b1, '{100, 100, 1, 1}},    // exactly at limit
    '{'{-8193, 0, 0, 0},              1'b0, '0}
  };

  // Fixed register sets for phases 1..4, in register order; later phases
  // draw random values.
  localparam logic [15:0] PHASE_REGS [4][6] = '{
    '{16'd32767, 16'd32767, 16'd65535, 16'd65535, 16'd32767, 16'd1},  // all max
    '{16'd1,     16'd1,     16'd0,     16'd0,     16'd0,     16'd0},  // limits 1, all else zero, balance off
    '{16'd0,     16'd200,   16'd40000, 16'd300,   16'd100,   16'd1},  // zero linear limit
    '{16'd200,   16'd0,     16'd65535, 16'd256,   16'd1,     16'd1}   // zero angular limit
  };

  // Idle percentages {sender gap, receiver stall}, cycled over phases.
  localparam int IDLE_MODES [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{23, 23}};

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // linear_cmd, angular_cmd, left_counts, right_counts
  logic [TICK_W-1:0]     s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // left_duty, right_duty, left_reverse, right_reverse
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block's registers and encoder sums.
  logic [LIM_W-1:0]  lin_limit  = 15'd8192;
  logic [LIM_W-1:0]  ang_limit  = 15'd16384;
  logic [HB_W-1:0]   half_base  = 16'd6554;
  logic [GAIN_W-1:0] gain       = 16'd51;
  logic [LIM_W-1:0]  band       = 15'd16;
  logic              bal_enable = 1'b1;
  logic [31:0]       left_sum   = '0;
  logic [31:0]       right_sum  = '0;

  duty_t pending_duties [$];
  int    fails     = 0;
  int    gap_pct   = 0;
  int    stall_pct = 0;
  duty_t got_duty;

  diff_drive_duty_mixer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp_cmd(logic signed [15:0] x, logic [LIM_W-1:0] lim);
    longint xv;
    longint lv;
    xv = x;
    lv = lim;
    if (xv > lv) return lv;
    if (xv < -lv) return -lv;
    return xv;
  endfunction

  // Wheel term is Q4.30; duty = floor(100*|term| / (limit<<16)), capped at 100.
  function automatic longint duty_pct(longint term);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    mag = (term < 0) ? -term : term;
    den = longint'(lin_limit) << 16;
    // zero limit: full duty on any motion at all
    if (den == 0) return (mag != 0) ? 100 : 0;
    q = mag * 100 / den;
    return (q > 100) ? 100 : longint'(q);
  endfunction

  function automatic longint pct_clamp(longint x);
    if (x < 0) return 0;
    if (x > 100) return 100;
    return x;
  endfunction

  // One control tick: saturate, mix, convert to duty, then balance trim.
  function automatic duty_t mix_tick(tick_t t);
    longint v, w, spin, tl, tr, pl, pr, delta;
    longint unsigned absw, err;
    logic signed [31:0] ls, rs;
    duty_t r;
    v    = clamp_cmd(t.linear_cmd, lin_limit);
    w    = clamp_cmd(t.angular_cmd, ang_limit);
    spin = w * longint'(half_base);
    tl   = v * 65536 - spin;
    tr   = v * 65536 + spin;
    pl   = duty_pct(tl);
    pr   = duty_pct(tr);
    absw = (w < 0) ? -w : w;
    left_sum  = left_sum + {{16{t.left_counts[15]}}, t.left_counts};
    right_sum = right_sum + {{16{t.right_counts[15]}}, t.right_counts};
    // trim only with balance on and driving (nearly) straight; sums survive otherwise
    if (bal_enable && absw < band) begin
      ls    = left_sum;
      rs    = right_sum;
      err   = (ls < rs) ? longint'(rs) - longint'(ls) : longint'(ls) - longint'(rs);
      err   = (err * gain) >> GAIN_FRAC;
      if (err > 1000) err = 1000;
      delta = (ls < rs) ? -longint'(err) : longint'(err);
      pl    = pct_clamp(pl - delta);
      pr    = pct_clamp(pr + delta);
      left_sum  = '0;
      right_sum = '0;
    end
    r.left_duty     = 7'(pl);
    r.right_duty    = 7'(pr);
    r.left_reverse  = (tl < 0);
    r.right_reverse = (tr < 0);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Holds tvalid high until the beat goes; leaves it high for back-to-back.
  task automatic send_tick(input tick_t t, input logic typed, input duty_t typed_want);
    duty_t predicted;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t.right_counts, t.left_counts, t.angular_cmd, t.linear_cmd};
    do @(posedge clk); while (!s_tready);
    // predictor always runs so the shadow sums stay in step
    predicted = mix_tick(t);
    pending_duties.push_back(typed ? typed_want : predicted);
  endtask

  // Sender stops until every result is back, then idles a while.
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // cfg_valid is left high; caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LINEAR_LIMIT:   lin_limit  = data[LIM_W-1:0];
      REG_ANGULAR_LIMIT:  ang_limit  = data[LIM_W-1:0];
      REG_HALF_BASE:      half_base  = data;
      REG_BALANCE_GAIN:   gain       = data;
      REG_STRAIGHT_BAND:  band       = data[LIM_W-1:0];
      REG_BALANCE_ENABLE: bal_enable = data[0];
      default: ;
    endcase
  endtask

  // Receiver back-pressure.
  always @(posedge clk)
    m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_duty.left_duty     = m_tdata[6:0];
      got_duty.right_duty    = m_tdata[13:7];
      got_duty.left_reverse  = m_tdata[14];
      got_duty.right_reverse = m_tdata[15];
      if (pending_duties.size() == 0) begin
        $error("duty beat with no tick outstanding: m_tdata=%h", m_tdata);
        fails++;
      end else begin
        check_field("left_duty", pending_duties[0].left_duty, got_duty.left_duty);
        check_field("right_duty", pending_duties[0].right_duty, got_duty.right_duty);
        check_field("left_reverse", pending_duties[0].left_reverse,
                    got_duty.left_reverse);
        check_field("right_reverse", pending_duties[0].right_reverse,
                    got_duty.right_reverse);
        void'(pending_duties.pop_front());
      end
    end
  end

  // Hang detector: any beat on any channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    tick_t t;
    int    k;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_LINEAR_LIMIT;
    cfg_data  <= '0;
    m_tready  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers change only with the pipe empty
      if (ph > 0) begin
        drain(SETTLE_CYCLES);
        if (ph <= 4) begin
          write_reg(REG_LINEAR_LIMIT,   PHASE_REGS[ph-1][0]);
          write_reg(REG_ANGULAR_LIMIT,  PHASE_REGS[ph-1][1]);
          write_reg(REG_HALF_BASE,      PHASE_REGS[ph-1][2]);
          write_reg(REG_BALANCE_GAIN,   PHASE_REGS[ph-1][3]);
          write_reg(REG_STRAIGHT_BAND,  PHASE_REGS[ph-1][4]);
          write_reg(REG_BALANCE_ENABLE, PHASE_REGS[ph-1][5]);
        end else begin
          // full 16-bit data but for the gain: bits above each register's width must drop
          write_reg(REG_UNUSED,         16'($urandom));
          write_reg(REG_LINEAR_LIMIT,   16'($urandom));
          write_reg(REG_ANGULAR_LIMIT,  16'($urandom));
          write_reg(REG_HALF_BASE,      16'($urandom));
          write_reg(REG_BALANCE_GAIN,   16'($urandom_range(1023)));
          write_reg(REG_STRAIGHT_BAND,  16'($urandom));
          write_reg(REG_BALANCE_ENABLE, 16'($urandom));
        end
        cfg_valid <= 1'b0;
      end

      gap_pct   = IDLE_MODES[ph % 4][0];
      stall_pct = IDLE_MODES[ph % 4][1];

      if (ph == 0)
        foreach (DIRECTED[i])
          send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        case ($urandom_range(2))
          0: t.linear_cmd = 16'($urandom);
          1: t.linear_cmd = 16'(int'($urandom_range(2 * lin_limit)) - int'(lin_limit));
          default: begin
            // right at the limit or one past it, either sign
            k = int'(lin_limit) + int'($urandom_range(1));
            t.linear_cmd = 16'($urandom_range(1) ? k : -k);
          end
        endcase
        // bias toward the straight band so the trim path gets exercised
        case ($urandom_range(3))
          0: t.angular_cmd = 16'($urandom);
          1: t.angular_cmd = 16'(int'($urandom_range(2 * band + 2)) - int'(band) - 1);
          2: t.angular_cmd = '0;
          default:
            t.angular_cmd = 16'(int'($urandom_range(2 * ang_limit)) - int'(ang_limit));
        endcase
        t.left_counts  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(600)) - 300);
        t.right_counts = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(600)) - 300);
        send_tick(t, 1'b0, '0);
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(199) == 0) drain(0);
      end
    end

    drain(TAIL_CYCLES);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
